>>> hw/rtl/agsh_pkg.sv
package agsh_pkg;

   // defaults for the top level parameters
   localparam int DEF_TABLE_ENTRIES = 1024;
   localparam int DEF_LIT_BITS      = 32;

   // fixed port widths
   localparam int LIT_W = 32;
   localparam int VAR_W = 31;

   localparam logic [VAR_W-1:0] VAR_MAX = '1;

   // request codes
   localparam logic REQ_GATE  = 1'b0;
   localparam logic REQ_CLEAR = 1'b1;

   // clause lengths
   typedef logic [1:0] len_type;
   localparam len_type LEN_NONE  = 2'd0;
   localparam len_type LEN_TWO   = 2'd2;
   localparam len_type LEN_THREE = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_HIT,
      ST_CL_LEFT,
      ST_CL_RIGHT,
      ST_CL_AND
   } state_type;

   // normalized gate request, literals ordered and sign extended
   typedef struct packed {
      logic signed [LIT_W-1:0] left;
      logic signed [LIT_W-1:0] right;
      logic signed [LIT_W-1:0] neg_left;
      logic signed [LIT_W-1:0] neg_right;
      logic signed [LIT_W-1:0] neg_gate;
      logic [VAR_W-1:0]        next_var;
      logic [VAR_W-1:0]        next_out;
   } gate_req_type;

   // one result transaction
   typedef struct packed {
      logic                    valid;
      logic [VAR_W-1:0]        gate_var;
      logic                    is_new;
      logic [VAR_W-1:0]        next_free_out;
      len_type                 clause_len;
      logic signed [LIT_W-1:0] clause_lit_a;
      logic signed [LIT_W-1:0] clause_lit_b;
      logic signed [LIT_W-1:0] clause_lit_c;
      logic                    table_full;
      logic                    last;
   } rsp_type;

endpackage

>>> hw/rtl/agsh_ram.sv
module agsh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end

endmodule

>>> hw/rtl/agsh_norm.sv
module agsh_norm
   import agsh_pkg::*;
#(
   parameter int LIT_BITS = DEF_LIT_BITS
) (
   input  logic signed [LIT_W-1:0] lit_left,
   input  logic signed [LIT_W-1:0] lit_right,
   input  logic [VAR_W-1:0]        next_free_var,
   output gate_req_type            req
);

   localparam int SHIFT = LIT_W - LIT_BITS;

   logic signed [LIT_W-1:0] left_sh;
   logic signed [LIT_W-1:0] right_sh;
   logic signed [LIT_W-1:0] left_ext;
   logic signed [LIT_W-1:0] right_ext;
   logic signed [LIT_W-1:0] lo;
   logic signed [LIT_W-1:0] hi;

   always_comb begin
      // sign extend from bit LIT_BITS-1
      left_sh   = lit_left <<< SHIFT;
      right_sh  = lit_right <<< SHIFT;
      left_ext  = left_sh >>> SHIFT;
      right_ext = right_sh >>> SHIFT;

      // smaller literal first
      if (left_ext > right_ext) begin
         lo = right_ext;
         hi = left_ext;
      end else begin
         lo = left_ext;
         hi = right_ext;
      end

      req.left      = lo;
      req.right     = hi;
      req.neg_left  = -lo;
      req.neg_right = -hi;
      req.neg_gate  = -$signed({1'b0, next_free_var});
      req.next_var  = next_free_var;
      req.next_out  = (next_free_var == VAR_MAX) ? VAR_MAX
                                                 : next_free_var + VAR_W'(1);
   end

endmodule

>>> hw/rtl/agsh_ctrl.sv
module agsh_ctrl
   import agsh_pkg::*;
#(
   parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
   parameter int LIT_BITS      = DEF_LIT_BITS,
   parameter int ADDR_W        = $clog2(TABLE_ENTRIES),
   parameter int DATA_W        = 2 * LIT_BITS + VAR_W
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              req_type,
   input  gate_req_type      req,
   output logic              busy,
   output logic              ram_we,
   output logic [ADDR_W-1:0] ram_addr,
   output logic [DATA_W-1:0] ram_wdata,
   input  logic [DATA_W-1:0] ram_rdata,
   output rsp_type           rsp
);

   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   issue_ff, issue_in;
   logic               pend_ff, pend_in;
   gate_req_type       req_ff, req_in;
   logic [VAR_W-1:0]   hit_gate_ff, hit_gate_in;
   logic               full_ff, full_in;

   logic [2*LIT_BITS-1:0] key;
   logic                  hit;
   logic                  done;
   logic                  has_room;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         issue_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         issue_ff <= issue_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      hit_gate_ff <= hit_gate_in;
      full_ff     <= full_in;
   end

   always_comb begin
      key      = {req_ff.left[LIT_BITS-1:0], req_ff.right[LIT_BITS-1:0]};
      hit      = pend_ff && (ram_rdata[DATA_W-1:VAR_W] == key);
      done     = (issue_ff == count_ff);
      has_room = (count_ff < FULL_CNT);
      busy     = (state_ff != ST_IDLE);

      state_in    = state_ff;
      count_in    = count_ff;
      issue_in    = issue_ff;
      pend_in     = 1'b0;
      req_in      = req_ff;
      hit_gate_in = hit_gate_ff;
      full_in     = full_ff;

      ram_we    = 1'b0;
      ram_addr  = issue_ff[ADDR_W-1:0];
      ram_wdata = {key, req_ff.next_var};

      rsp               = '0;
      rsp.gate_var      = req_ff.next_var;
      rsp.is_new        = 1'b1;
      rsp.next_free_out = req_ff.next_out;
      rsp.table_full    = full_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_type == REQ_CLEAR) begin
                  count_in = '0;
               end else begin
                  req_in   = req;
                  issue_in = '0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (hit) begin
               hit_gate_in = ram_rdata[VAR_W-1:0];
               state_in    = ST_HIT;
            end else if (done) begin
               // miss: append at the fill count if there is room
               full_in = !has_room;
               if (has_room) begin
                  ram_we   = 1'b1;
                  ram_addr = count_ff[ADDR_W-1:0];
                  count_in = count_ff + CNT_ONE;
               end
               state_in = ST_CL_LEFT;
            end else begin
               issue_in = issue_ff + CNT_ONE;
               pend_in  = 1'b1;
            end
         end
         ST_HIT: begin
            rsp.valid         = 1'b1;
            rsp.gate_var      = hit_gate_ff;
            rsp.is_new        = 1'b0;
            rsp.next_free_out = req_ff.next_var;
            rsp.clause_len    = LEN_NONE;
            rsp.table_full    = 1'b0;
            rsp.last          = 1'b1;
            state_in          = ST_IDLE;
         end
         ST_CL_LEFT: begin
            rsp.valid        = 1'b1;
            rsp.clause_len   = LEN_TWO;
            rsp.clause_lit_a = req_ff.left;
            rsp.clause_lit_b = req_ff.neg_gate;
            state_in         = ST_CL_RIGHT;
         end
         ST_CL_RIGHT: begin
            rsp.valid        = 1'b1;
            rsp.clause_len   = LEN_TWO;
            rsp.clause_lit_a = req_ff.right;
            rsp.clause_lit_b = req_ff.neg_gate;
            state_in         = ST_CL_AND;
         end
         ST_CL_AND: begin
            rsp.valid        = 1'b1;
            rsp.clause_len   = LEN_THREE;
            rsp.clause_lit_a = req_ff.neg_left;
            rsp.clause_lit_b = req_ff.neg_right;
            rsp.clause_lit_c = $signed({1'b0, req_ff.next_var});
            rsp.last         = 1'b1;
            state_in         = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> hw/rtl/and_gate_structural_hash_top.sv
// and-gate structural hash with tseitin clause output
//
// input channel: a transaction is taken on a rising edge with start high and
// busy low. req_type selects a gate lookup or a table clear. the two literals
// are ordered (smaller first) and looked up in the gate table.
// result channel: each result sits on the rsp_ ports for one cycle with
// rsp_valid high; the receiver cannot stall, so results never wait.
// a hit gives one result (stored gate, clause_len 0). a miss takes the
// caller's next free variable as the gate, stores it while there is room, and
// gives three clause results, rsp_last on the third.
// a clear gives no result and leaves busy low.
// the table is searched one entry per cycle through a single-port ram with
// registered read; a miss reads every stored gate and a hit ends the search
// at its entry, then the results follow. busy stays high from accept to the
// last result.
// reset empties the table by zeroing the fill count; no ram sweep is needed.
module and_gate_structural_hash_top
   import agsh_pkg::*;
#(
   parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
   parameter int LIT_BITS      = DEF_LIT_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic                    req_type,
   input  logic signed [LIT_W-1:0] req_lit_left,
   input  logic signed [LIT_W-1:0] req_lit_right,
   input  logic [VAR_W-1:0]        req_next_free_var,
   output logic                    rsp_valid,
   output logic [VAR_W-1:0]        rsp_gate_var,
   output logic                    rsp_is_new,
   output logic [VAR_W-1:0]        rsp_next_free_out,
   output logic [1:0]              rsp_clause_len,
   output logic signed [LIT_W-1:0] rsp_clause_lit_a,
   output logic signed [LIT_W-1:0] rsp_clause_lit_b,
   output logic signed [LIT_W-1:0] rsp_clause_lit_c,
   output logic                    rsp_table_full,
   output logic                    rsp_last
);

   // one ram row: ordered key (two literals) and the gate variable
   localparam int ADDR_W = $clog2(TABLE_ENTRIES);
   localparam int DATA_W = 2 * LIT_BITS + VAR_W;

   gate_req_type      norm_req;
   rsp_type           rsp;
   logic              ram_we;
   logic [ADDR_W-1:0] ram_addr;
   logic [DATA_W-1:0] ram_wdata;
   logic [DATA_W-1:0] ram_rdata;

   // literal sign extension, ordering and negation
   agsh_norm #(
      .LIT_BITS(LIT_BITS)
   ) u_norm (
      .lit_left      (req_lit_left),
      .lit_right     (req_lit_right),
      .next_free_var (req_next_free_var),
      .req           (norm_req)
   );

   // search sequencer, fill count and result sequencing
   agsh_ctrl #(
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .LIT_BITS     (LIT_BITS),
      .ADDR_W       (ADDR_W),
      .DATA_W       (DATA_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_type  (req_type),
      .req       (norm_req),
      .busy      (busy),
      .ram_we    (ram_we),
      .ram_addr  (ram_addr),
      .ram_wdata (ram_wdata),
      .ram_rdata (ram_rdata),
      .rsp       (rsp)
   );

   // gate table, rows filled in order of creation
   agsh_ram #(
      .WIDTH(DATA_W),
      .DEPTH(TABLE_ENTRIES)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign rsp_valid         = rsp.valid;
   assign rsp_gate_var      = rsp.gate_var;
   assign rsp_is_new        = rsp.is_new;
   assign rsp_next_free_out = rsp.next_free_out;
   assign rsp_clause_len    = rsp.clause_len;
   assign rsp_clause_lit_a  = rsp.clause_lit_a;
   assign rsp_clause_lit_b  = rsp.clause_lit_b;
   assign rsp_clause_lit_c  = rsp.clause_lit_c;
   assign rsp_table_full    = rsp.table_full;
   assign rsp_last          = rsp.last;

   // a result only comes out while a transaction is in flight
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe without a transaction in flight");

   // the final result frees the block for the next transaction
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |=> !busy)
      else $error("busy held after the final result");

   // a table hit is a single result with no clause
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_is_new) |-> (rsp_last && rsp_clause_len == LEN_NONE))
      else $error("hit result malformed");

   // the three-literal clause closes a miss, after two two-literal clauses
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_clause_len == LEN_THREE) |->
         (rsp_last && $past(rsp_valid) && $past(rsp_clause_len) == LEN_TWO))
      else $error("clause order broken");

endmodule

>>> verif/tb_and_gate_structural_hash_top.sv
`timescale 1ns / 100ps

// and-gate structural hash testbench
//
// stimulus drives gate lookups and table clears through the start/busy
// command port. every accepted transaction runs through a local copy of the
// gate table (an associative array keyed by the ordered literal pair) which
// predicts the hit result or the three tseitin clause results. results are
// taken off the rsp_ ports on every strobe and compared field by field with
// the oldest prediction.
module tb_and_gate_structural_hash_top;
   import agsh_pkg::*;

   localparam int ENTRIES     = DEF_TABLE_ENTRIES;
   localparam int LIT_PAD     = LIT_W - DEF_LIT_BITS;
   localparam int CYCLE_LIMIT = 6_000_000;
   localparam int MAX_PRINTED = 40;

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic                    req_type;
   logic signed [LIT_W-1:0] req_lit_left;
   logic signed [LIT_W-1:0] req_lit_right;
   logic [VAR_W-1:0]        req_next_free_var;
   logic                    rsp_valid;
   logic [VAR_W-1:0]        rsp_gate_var;
   logic                    rsp_is_new;
   logic [VAR_W-1:0]        rsp_next_free_out;
   logic [1:0]              rsp_clause_len;
   logic signed [LIT_W-1:0] rsp_clause_lit_a;
   logic signed [LIT_W-1:0] rsp_clause_lit_b;
   logic signed [LIT_W-1:0] rsp_clause_lit_c;
   logic                    rsp_table_full;
   logic                    rsp_last;

   // local gate table: ordered literal pair -> gate variable
   logic [VAR_W-1:0] gate_of_key [logic [2*LIT_W-1:0]];
   int unsigned      stored_gates;
   // results still owed by the block, oldest first
   rsp_type          due_gate_results [$];
   // what a well-behaved caller would pass as its next free variable
   logic [VAR_W-1:0] caller_next_var;

   int unsigned sent_count;
   int unsigned mismatch_count;
   int unsigned cycle_count;
   logic        gaps_enabled;

   and_gate_structural_hash_top #(
      .TABLE_ENTRIES(ENTRIES),
      .LIT_BITS(DEF_LIT_BITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_type(req_type),
      .req_lit_left(req_lit_left),
      .req_lit_right(req_lit_right),
      .req_next_free_var(req_next_free_var),
      .rsp_valid(rsp_valid),
      .rsp_gate_var(rsp_gate_var),
      .rsp_is_new(rsp_is_new),
      .rsp_next_free_out(rsp_next_free_out),
      .rsp_clause_len(rsp_clause_len),
      .rsp_clause_lit_a(rsp_clause_lit_a),
      .rsp_clause_lit_b(rsp_clause_lit_b),
      .rsp_clause_lit_c(rsp_clause_lit_c),
      .rsp_table_full(rsp_table_full),
      .rsp_last(rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop in case the block hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // one line per mismatch, printing capped so a broken block cannot flood the log
   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED)
         $display("mismatch on %s: got %0h, want %0h (cycle %0d)",
                  what, got, want, cycle_count);
   endtask

   // ---------------------------------------------------------------------------
   // gate table prediction
   // ---------------------------------------------------------------------------

   task automatic clear_gates;
      gate_of_key.delete();
      stored_gates = 0;
   endtask

   // order the literals, look the pair up, and queue the hit result or the
   // three clauses (left, -g), (right, -g), (-left, -right, g)
   task automatic hash_gate(input logic [LIT_W-1:0] lit_a, input logic [LIT_W-1:0] lit_b,
                            input logic [VAR_W-1:0] next_var);
      logic signed [LIT_W-1:0] lo;
      logic signed [LIT_W-1:0] hi;
      logic signed [LIT_W-1:0] swap;
      logic signed [LIT_W-1:0] neg_gate;
      logic [2*LIT_W-1:0]      key;
      logic [VAR_W-1:0]        next_out;
      logic                    full;
      rsp_type                 r;
      // sign extend from the configured literal width
      lo = $signed(lit_a << LIT_PAD) >>> LIT_PAD;
      hi = $signed(lit_b << LIT_PAD) >>> LIT_PAD;
      if (lo > hi) begin
         swap = lo;
         lo = hi;
         hi = swap;
      end
      key = {lo, hi};
      r = '0;
      r.valid = 1'b1;
      if (gate_of_key.exists(key)) begin
         // hit: stored gate, no clause, caller's counter passed through
         r.gate_var      = gate_of_key[key];
         r.next_free_out = next_var;
         r.clause_len    = LEN_NONE;
         r.last          = 1'b1;
         due_gate_results.push_back(r);
      end else begin
         next_out = (next_var == VAR_MAX) ? VAR_MAX : next_var + VAR_W'(1);
         full = (stored_gates >= ENTRIES);
         if (!full) begin
            gate_of_key[key] = next_var;
            stored_gates++;
         end
         // negation wraps, so -(-2^31) stays -2^31
         neg_gate = -$signed({1'b0, next_var});
         r.gate_var      = next_var;
         r.is_new        = 1'b1;
         r.next_free_out = next_out;
         r.table_full    = full;
         r.clause_len    = LEN_TWO;
         r.clause_lit_a  = lo;
         r.clause_lit_b  = neg_gate;
         due_gate_results.push_back(r);
         r.clause_lit_a  = hi;
         due_gate_results.push_back(r);
         r.clause_len    = LEN_THREE;
         r.clause_lit_a  = -lo;
         r.clause_lit_b  = -hi;
         r.clause_lit_c  = $signed({1'b0, next_var});
         r.last          = 1'b1;
         due_gate_results.push_back(r);
      end
      caller_next_var = r.next_free_out;
   endtask

   // ---------------------------------------------------------------------------
   // result checking: the receiver never stalls, so every strobe is a transaction
   // ---------------------------------------------------------------------------

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid !== 1'b0) begin
         if (due_gate_results.size() == 0) begin
            report_mismatch("unexpected result, gate_var", rsp_gate_var, '0);
         end else begin
            want = due_gate_results.pop_front();
            if (rsp_gate_var !== want.gate_var)
               report_mismatch("gate_var", rsp_gate_var, want.gate_var);
            if (rsp_is_new !== want.is_new)
               report_mismatch("is_new", rsp_is_new, want.is_new);
            if (rsp_next_free_out !== want.next_free_out)
               report_mismatch("next_free_out", rsp_next_free_out, want.next_free_out);
            if (rsp_clause_len !== want.clause_len)
               report_mismatch("clause_len", rsp_clause_len, want.clause_len);
            if (rsp_clause_lit_a !== want.clause_lit_a)
               report_mismatch("clause_lit_a", rsp_clause_lit_a, want.clause_lit_a);
            if (rsp_clause_lit_b !== want.clause_lit_b)
               report_mismatch("clause_lit_b", rsp_clause_lit_b, want.clause_lit_b);
            if (rsp_clause_lit_c !== want.clause_lit_c)
               report_mismatch("clause_lit_c", rsp_clause_lit_c, want.clause_lit_c);
            if (rsp_table_full !== want.table_full)
               report_mismatch("table_full", rsp_table_full, want.table_full);
            if (rsp_last !== want.last)
               report_mismatch("last", rsp_last, want.last);
         end
      end
   end

   // ---------------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------------

   // present one transaction and hold it until the block takes it; unless a gap
   // follows, start stays high so a following call can reuse the same cycle
   task automatic send_request(input logic kind, input logic [LIT_W-1:0] lit_a,
                               input logic [LIT_W-1:0] lit_b,
                               input logic [VAR_W-1:0] next_var);
      req_type          <= kind;
      req_lit_left      <= lit_a;
      req_lit_right     <= lit_b;
      req_next_free_var <= next_var;
      start             <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      // accepted at this edge
      if (kind == REQ_CLEAR)
         clear_gates();
      else
         hash_gate(lit_a, lit_b, next_var);
      sent_count++;
      // random idle burst, lands on any phase of the block's search or output
      if (gaps_enabled && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   // sender pauses until the block owes nothing
   task automatic wait_for_results;
      start <= 1'b0;
      do @(posedge clock); while (due_gate_results.size() != 0);
   endtask

   // literals: a mix of random values, corners and small values
   function automatic logic [LIT_W-1:0] pick_literal();
      logic [LIT_W-1:0] lit;
      case ($urandom_range(0, 9))
         0: lit = 32'h7FFF_FFFF;
         1: lit = 32'h8000_0001;
         2: lit = 32'h8000_0000;
         3: lit = '0;
         4, 5: begin
            lit = LIT_W'($urandom_range(1, 64));
            if ($urandom_range(0, 1) == 1) lit = -lit;
         end
         default: lit = $urandom();
      endcase
      return lit;
   endfunction

   // next free variable: mostly what a real caller passes, sometimes anything
   function automatic logic [VAR_W-1:0] pick_next_var();
      logic [VAR_W-1:0] v;
      case ($urandom_range(0, 11))
         0: v = VAR_MAX;
         1: v = '0;
         2, 3: v = VAR_W'($urandom());
         default: v = caller_next_var;
      endcase
      return v;
   endfunction

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------

   // literal extremes, swapped order hits, saturation, zero variable, clear
   task automatic test_corner_literals;
      send_request(REQ_CLEAR, $urandom(), $urandom(), VAR_W'($urandom()));
      send_request(REQ_GATE, 32'h7FFF_FFFF, 32'h8000_0001, 31'd1);
      send_request(REQ_GATE, 32'h8000_0000, 32'h8000_0000, 31'd2);
      send_request(REQ_GATE, 32'h0000_0000, 32'h0000_0000, '0);
      send_request(REQ_GATE, 32'h0000_0001, 32'hFFFF_FFFF, VAR_MAX);
      // earlier pairs in the opposite order must hit, mixed with new pairs
      send_request(REQ_GATE, 32'hFFFF_FFFF, 32'h0000_0001, 31'd5);
      send_request(REQ_GATE, 32'h8000_0001, 32'h7FFF_FFFF, 31'd6);
      send_request(REQ_GATE, 32'h0000_0005, 32'h0000_0003, VAR_MAX - VAR_W'(1));
      send_request(REQ_GATE, 32'h0000_0003, 32'h0000_0005, 31'd100);
      send_request(REQ_GATE, 32'h8000_0000, 32'h7FFF_FFFF, 31'd7);
      send_request(REQ_GATE, 32'h7FFF_FFFF, 32'h8000_0000, 31'd8);
      send_request(REQ_GATE, 32'h0000_0000, 32'h0000_0000, 31'd9);
      // clear with all fields high, then the old pair misses again
      send_request(REQ_CLEAR, '1, '1, '1);
      send_request(REQ_GATE, 32'h0000_0003, 32'h0000_0005, 31'd200);
      send_request(REQ_GATE, 32'h0000_0005, 32'h0000_0003, 31'd201);
      send_request(REQ_GATE, 32'h8000_0000, 32'h8000_0000, VAR_MAX);
      send_request(REQ_GATE, 32'h8000_0000, 32'h8000_0000, 31'd3);
   endtask

   // the sender holds off until everything owed has come, then resumes
   task automatic test_pause_until_drained;
      send_request(REQ_GATE, 32'h0000_0011, 32'hFFFF_FFEE, caller_next_var);
      send_request(REQ_GATE, 32'h1234_5678, 32'h8765_4321, caller_next_var);
      wait_for_results;
      send_request(REQ_GATE, 32'hFFFF_FFEE, 32'h0000_0011, caller_next_var);
      wait_for_results;
      send_request(REQ_CLEAR, '0, '0, '0);
   endtask

   // realistic traffic: small literal pools give many hits, with clears and
   // full-range noise; the table is kept short so searches stay quick
   task automatic test_random_traffic(input int unsigned item_goal);
      logic [LIT_W-1:0] pool [6];
      int unsigned      first_item;
      first_item = sent_count;
      while (sent_count - first_item < item_goal) begin
         foreach (pool[i]) pool[i] = pick_literal();
         gaps_enabled = ($urandom_range(0, 3) != 0);
         repeat ($urandom_range(4, 16)) begin
            case ($urandom_range(0, 15))
               0: send_request(REQ_CLEAR, $urandom(), $urandom(), VAR_W'($urandom()));
               1: send_request(REQ_GATE, $urandom(), $urandom(), VAR_W'($urandom()));
               default:
                  send_request(REQ_GATE, pool[$urandom_range(0, 5)],
                               pool[$urandom_range(0, 5)], pick_next_var());
            endcase
         end
         if (stored_gates > 40)
            send_request(REQ_CLEAR, $urandom(), $urandom(), VAR_W'($urandom()));
         if ($urandom_range(0, 7) == 0)
            wait_for_results;
      end
      gaps_enabled = 1'b1;
   endtask

   // closing stretch with no idling at all on the request side
   task automatic test_back_to_back;
      logic [LIT_W-1:0] pool [4];
      gaps_enabled = 1'b0;
      foreach (pool[i]) pool[i] = pick_literal();
      repeat (30) begin
         if ($urandom_range(0, 11) == 0)
            send_request(REQ_CLEAR, $urandom(), $urandom(), VAR_W'($urandom()));
         else
            send_request(REQ_GATE, pool[$urandom_range(0, 3)], pool[$urandom_range(0, 3)],
                         pick_next_var());
      end
   endtask

   // ---------------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------------

   initial begin
      reset             = 1'b1;
      start             = 1'b0;
      req_type          = REQ_GATE;
      req_lit_left      = '0;
      req_lit_right     = '0;
      req_next_free_var = '0;
      stored_gates      = 0;
      caller_next_var   = 31'd1;
      sent_count        = 0;
      mismatch_count    = 0;
      cycle_count       = 0;
      gaps_enabled      = 1'b1;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_corner_literals;
      test_pause_until_drained;
      test_random_traffic(175);
      test_back_to_back;

      // let every owed result arrive, then watch a little longer for strays
      wait_for_results;
      repeat (16) @(posedge clock);

      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/agsh_pkg.sv
hw/rtl/agsh_ram.sv
hw/rtl/agsh_norm.sv
hw/rtl/agsh_ctrl.sv
hw/rtl/and_gate_structural_hash_top.sv
verif/tb_and_gate_structural_hash_top.sv
